@@ rtl/core/bpcs_pkg.sv @@
// ----------------------------------------------------------------------------
// Box placement package
// Shared types, operation codes and register indexes for the box table.
// ----------------------------------------------------------------------------
package bpcs_pkg;

   localparam int SizeBits = 15;
   localparam int AreaBits = 31;

   localparam logic [1:0] OP_PLACE = 2'd0;
   localparam logic [1:0] OP_EVAL  = 2'd1;
   localparam logic [1:0] OP_POINT = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [1:0] REG_SIZE_X = 2'd0;
   localparam logic [1:0] REG_SIZE_Y = 2'd1;
   localparam logic [1:0] REG_SIZE_Z = 2'd2;

   localparam logic [AreaBits-1:0] AreaMax = {AreaBits{1'b1}};

   typedef logic [SizeBits-1:0] size_type;

   typedef struct packed {
      logic       valid;
      logic [1:0] op;
      logic       last;
   } token_type;

   typedef struct packed {
      logic             ovl;
      logic             hit;
      logic [AreaBits:0] sup;
   } acc_type;

endpackage

@@ rtl/core/bpcs_cell.sv @@
// ----------------------------------------------------------------------------
// Box table cell
// Holds one placed box, compares it with the query passing by and hands the
// query and the running results to the next cell.
// ----------------------------------------------------------------------------
module bpcs_cell #(
   parameter int CoordBits = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_en,
   input  logic                               wr_valid,
   input  logic                               clr,
   input  logic signed [CoordBits-1:0]        wr_pos [3],
   input  bpcs_pkg::size_type                 wr_size [3],
   input  bpcs_pkg::token_type                tok_in,
   input  logic signed [CoordBits-1:0]        qp_in [3],
   input  bpcs_pkg::size_type                 qd_in [3],
   input  bpcs_pkg::acc_type                  acc_in,
   output bpcs_pkg::token_type                tok_out,
   output logic signed [CoordBits-1:0]        qp_out [3],
   output bpcs_pkg::size_type                 qd_out [3],
   output bpcs_pkg::acc_type                  acc_out
);
   import bpcs_pkg::*;

   localparam int EB = ((CoordBits > SizeBits) ? CoordBits : SizeBits) + 2;

   logic                        valid_ff;
   logic signed [CoordBits-1:0] ep_ff [3];
   size_type                    es_ff [3];
   token_type                   tok_ff;
   logic signed [CoordBits-1:0] qp_ff [3];
   size_type                    qd_ff [3];
   acc_type                     acc_ff, acc_in2;

   logic signed [EB-1:0] alo [3], ahi [3], blo [3], bhi [3];
   logic                 ovl, hit, top;
   logic signed [EB-1:0] lo_x, hi_x, lo_z, hi_z;
   logic [SizeBits:0]    wx, wz;
   logic [AreaBits:0]    prod, sum;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         alo[k] = EB'(ep_ff[k]);
         ahi[k] = alo[k] + EB'($signed({1'b0, es_ff[k]}));
         blo[k] = EB'(qp_in[k]);
         bhi[k] = blo[k] + EB'($signed({1'b0, qd_in[k]}));
      end
      ovl = valid_ff;
      hit = valid_ff;
      for (int k = 0; k < 3; k++) begin
         if (ahi[k] <= blo[k] || bhi[k] <= alo[k]) ovl = 1'b0;
         if (blo[k] < alo[k] || blo[k] >= ahi[k]) hit = 1'b0;
      end
      top  = valid_ff && (ahi[1] == blo[1]);
      lo_x = (alo[0] > blo[0]) ? alo[0] : blo[0];
      hi_x = (ahi[0] < bhi[0]) ? ahi[0] : bhi[0];
      lo_z = (alo[2] > blo[2]) ? alo[2] : blo[2];
      hi_z = (ahi[2] < bhi[2]) ? ahi[2] : bhi[2];
      wx = (top && lo_x < hi_x) ? (SizeBits+1)'(hi_x - lo_x) : '0;
      wz = (top && lo_z < hi_z) ? (SizeBits+1)'(hi_z - lo_z) : '0;
      prod = (AreaBits+1)'(wx) * (AreaBits+1)'(wz);
      sum  = acc_in.sup + prod;
      acc_in2.ovl = acc_in.ovl | ovl;
      acc_in2.hit = acc_in.hit | hit;
      acc_in2.sup = (sum > {1'b0, AreaMax}) ? {1'b0, AreaMax} : sum;
   end

   always_ff @(posedge clock) begin
      if (reset || clr) begin
         valid_ff <= 1'b0;
      end else if (wr_en) begin
         valid_ff <= wr_valid;
      end
      if (wr_en) begin
         ep_ff <= wr_pos;
         es_ff <= wr_size;
      end
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in;
      end
      qp_ff  <= qp_in;
      qd_ff  <= qd_in;
      acc_ff <= acc_in2;
   end

   assign tok_out = tok_ff;
   assign qp_out  = qp_ff;
   assign qd_out  = qd_ff;
   assign acc_out = acc_ff;

endmodule

@@ rtl/core/box_placement_collision_support.sv @@
// ----------------------------------------------------------------------------
// Box placement collision and support
// Table of placed boxes with overlap, bounds, support area and point tests.
// ----------------------------------------------------------------------------
// Channel  Ports   Handshake
// request  req_*   start high while busy low is a transfer
// result   rsp_*   rsp_strobe marks a one-cycle transfer, no back-pressure
// config   csr_*   csr_write_enable high writes csr_index
//
// Place and clear finish as the token leaves the input register. Evaluate and
// point test finish once the query has walked the chain of cells.
// Reset empties the table and clears the container registers.
// The receiver cannot stall; busy holds off new requests.
module box_placement_collision_support #(
   parameter int MAX_PLACEMENTS = 64,
   parameter int COORD_BITS     = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [1:0]                           req_operation,
   input  logic signed [COORD_BITS-1:0]         req_pos_x,
   input  logic signed [COORD_BITS-1:0]         req_pos_y,
   input  logic signed [COORD_BITS-1:0]         req_pos_z,
   input  bpcs_pkg::size_type                   req_base_size_x,
   input  bpcs_pkg::size_type                   req_base_size_y,
   input  bpcs_pkg::size_type                   req_base_size_z,
   input  logic [2:0]                           req_orientation,
   output logic                                 rsp_strobe,
   output logic                                 rsp_status,
   output logic                                 rsp_in_bounds,
   output logic                                 rsp_overlaps,
   output logic                                 rsp_on_floor,
   output logic [bpcs_pkg::AreaBits-1:0]        rsp_support_sum,
   output logic [bpcs_pkg::AreaBits-1:0]        rsp_base_area,
   output logic                                 rsp_point_kept,
   input  logic                                 csr_write_enable,
   input  logic [1:0]                           csr_index,
   input  bpcs_pkg::size_type                   csr_data
);
   import bpcs_pkg::*;

   localparam int N  = MAX_PLACEMENTS;
   localparam int CB = $clog2(N + 1);
   localparam int EB = ((COORD_BITS > SizeBits) ? COORD_BITS : SizeBits) + 1;

   size_type             cont_ff [3];
   logic [CB-1:0]        count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic                 full;

   token_type                    tok  [N+1];
   logic signed [COORD_BITS-1:0] qp   [N+1][3];
   size_type                     qd   [N+1][3];
   acc_type                      acc  [N+1];
   logic [N-1:0]                 wr_en;

   token_type                    tok_ff;
   logic signed [COORD_BITS-1:0] p_ff [3];
   size_type                     d_ff [3];
   logic                         inb_ff, pin_ff, full_ff, floor_ff;
   logic [AreaBits-1:0]          base_ff;

   size_type             d [3];
   logic signed [COORD_BITS-1:0] p [3];
   logic                 inb, pin;
   logic signed [EB:0]   tip, lim;

   logic                 strobe_ff, status_ff, ib_ff, ov_ff, fl_ff, pk_ff;
   logic [AreaBits-1:0]  sup_ff, bar_ff;
   logic                 accept;
   logic                 done_short;

   assign accept = start && !busy_ff;
   assign full   = (count_ff >= CB'(N));
   assign p[0] = req_pos_x;
   assign p[1] = req_pos_y;
   assign p[2] = req_pos_z;

   always_comb begin
      case (req_orientation)
         3'd1: d = '{req_base_size_x, req_base_size_z, req_base_size_y};
         3'd2: d = '{req_base_size_y, req_base_size_x, req_base_size_z};
         3'd3: d = '{req_base_size_y, req_base_size_z, req_base_size_x};
         3'd4: d = '{req_base_size_z, req_base_size_x, req_base_size_y};
         3'd5: d = '{req_base_size_z, req_base_size_y, req_base_size_x};
         default: d = '{req_base_size_x, req_base_size_y, req_base_size_z};
      endcase
      inb = 1'b1;
      pin = 1'b1;
      for (int k = 0; k < 3; k++) begin
         tip = (EB+1)'(p[k]) + (EB+1)'($signed({1'b0, d[k]}));
         lim = (EB+1)'($signed({1'b0, cont_ff[k]}));
         if (p[k] < 0 || tip > lim) inb = 1'b0;
         if (p[k] < 0 || (EB+1)'(p[k]) > lim) pin = 1'b0;
      end
   end

   always_comb begin
      count_in = count_ff;
      busy_in  = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
         if (req_operation == OP_CLEAR) count_in = '0;
         else if (req_operation == OP_PLACE && !full) count_in = count_ff + 1'b1;
      end else if (done_short || tok[N].valid) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         tok_ff   <= '0;
         cont_ff  <= '{default: '0};
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         tok_ff.valid <= accept;
         tok_ff.op    <= req_operation;
         tok_ff.last  <= 1'b0;
         if (csr_write_enable) begin
            unique case (csr_index)
               REG_SIZE_X: cont_ff[0] <= csr_data;
               REG_SIZE_Y: cont_ff[1] <= csr_data;
               REG_SIZE_Z: cont_ff[2] <= csr_data;
               default: ;
            endcase
         end
      end
      if (accept) begin
         p_ff     <= p;
         d_ff     <= d;
         inb_ff   <= inb;
         pin_ff   <= pin;
         full_ff  <= full;
         floor_ff <= (req_pos_y == '0);
         base_ff  <= AreaBits'(d[0]) * AreaBits'(d[2]);
      end
   end

   // Place writes the cell at the entry count held before the place, when the token leaves stage 0.
   always_comb begin
      for (int i = 0; i < N; i++) begin
         wr_en[i] = tok_ff.valid && tok_ff.op == OP_PLACE && !full_ff &&
                    (count_ff == CB'(i + 1));
      end
   end

   assign tok[0] = (tok_ff.op == OP_EVAL || tok_ff.op == OP_POINT) ? tok_ff : '0;
   assign qp[0]  = p_ff;
   assign qd[0]  = d_ff;
   assign acc[0] = '0;

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : g_cell
         bpcs_cell #(.CoordBits(COORD_BITS)) u_cell (
            .clock    (clock),
            .reset    (reset),
            .wr_en    (wr_en[g]),
            .wr_valid (1'b1),
            .clr      (tok_ff.valid && tok_ff.op == OP_CLEAR),
            .wr_pos   (p_ff),
            .wr_size  (d_ff),
            .tok_in   (tok[g]),
            .qp_in    (qp[g]),
            .qd_in    (qd[g]),
            .acc_in   (acc[g]),
            .tok_out  (tok[g+1]),
            .qp_out   (qp[g+1]),
            .qd_out   (qd[g+1]),
            .acc_out  (acc[g+1])
         );
      end
   endgenerate

   assign done_short = tok_ff.valid && (tok_ff.op == OP_PLACE || tok_ff.op == OP_CLEAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= done_short || tok[N].valid;
      end
      status_ff <= done_short && tok_ff.op == OP_PLACE && full_ff;
      ib_ff <= 1'b0; ov_ff <= 1'b0; fl_ff <= 1'b0; pk_ff <= 1'b0;
      sup_ff <= '0; bar_ff <= '0;
      if (tok[N].valid && tok[N].op == OP_EVAL) begin
         ib_ff  <= inb_ff;
         ov_ff  <= acc[N].ovl;
         fl_ff  <= floor_ff;
         sup_ff <= floor_ff ? base_ff : AreaBits'(acc[N].sup);
         bar_ff <= base_ff;
      end
      if (tok[N].valid && tok[N].op == OP_POINT) begin
         pk_ff <= pin_ff && !acc[N].hit;
      end
   end

   assign busy               = busy_ff;
   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_in_bounds      = ib_ff;
   assign rsp_overlaps       = ov_ff;
   assign rsp_on_floor       = fl_ff;
   assign rsp_support_sum    = sup_ff;
   assign rsp_base_area      = bar_ff;
   assign rsp_point_kept     = pk_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(N)) else $error("entry count beyond table size");
   a_busy_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("result while still busy");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("busy not raised after transfer");

endmodule

@@ test/box_placement_collision_support_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Box placement collision and support testbench
// Drives place, evaluate, point test and clear requests under several
// container settings and gap patterns, predicts every result in a box table
// model and checks each result strobe against the oldest prediction.
// ----------------------------------------------------------------------------

typedef struct {
   logic        status;
   logic        in_bounds;
   logic        overlaps;
   logic        on_floor;
   logic [30:0] support_sum;
   logic [30:0] base_area;
   logic        point_kept;
} box_result_type;

class box_scoreboard;
   longint         box_pos[64][3];
   longint         box_dim[64][3];
   int             box_count;
   longint         container[3];
   box_result_type pending[$];
   int             errors;

   function void clear_all();
      box_count = 0;
      container[0] = 0;
      container[1] = 0;
      container[2] = 0;
      errors = 0;
   endfunction

   function void note_request(logic [1:0] op, logic signed [15:0] px,
                              logic signed [15:0] py, logic signed [15:0] pz,
                              logic [14:0] bx, logic [14:0] by, logic [14:0] bz,
                              logic [2:0] orient);
      box_result_type r;
      longint p[3];
      longint d[3];
      longint base;
      longint sup;
      longint x1, x2, z1, z2;
      bit inb, ovl, keep, hit;
      r = '{default: '0};
      p[0] = px;
      p[1] = py;
      p[2] = pz;
      case (orient)
         3'd1: begin d[0] = bx; d[1] = bz; d[2] = by; end
         3'd2: begin d[0] = by; d[1] = bx; d[2] = bz; end
         3'd3: begin d[0] = by; d[1] = bz; d[2] = bx; end
         3'd4: begin d[0] = bz; d[1] = bx; d[2] = by; end
         3'd5: begin d[0] = bz; d[1] = by; d[2] = bx; end
         default: begin d[0] = bx; d[1] = by; d[2] = bz; end
      endcase
      case (op)
         bpcs_pkg::OP_PLACE: begin
            if (box_count >= 64) begin
               r.status = 1'b1;
            end else begin
               for (int k = 0; k < 3; k++) begin
                  box_pos[box_count][k] = p[k];
                  box_dim[box_count][k] = d[k];
               end
               box_count++;
            end
         end
         bpcs_pkg::OP_EVAL: begin
            inb = 1;
            ovl = 0;
            base = d[0] * d[2];
            sup = 0;
            for (int k = 0; k < 3; k++)
               if (p[k] < 0 || p[k] + d[k] > container[k]) inb = 0;
            for (int i = 0; i < box_count; i++) begin
               hit = 1;
               for (int k = 0; k < 3; k++)
                  if (box_pos[i][k] + box_dim[i][k] <= p[k] ||
                      p[k] + d[k] <= box_pos[i][k]) hit = 0;
               if (hit) ovl = 1;
            end
            if (p[1] == 0) begin
               sup = base;
            end else begin
               for (int i = 0; i < box_count; i++) begin
                  if (box_pos[i][1] + box_dim[i][1] == p[1]) begin
                     x1 = (p[0] > box_pos[i][0]) ? p[0] : box_pos[i][0];
                     x2 = (p[0] + d[0] < box_pos[i][0] + box_dim[i][0]) ?
                          p[0] + d[0] : box_pos[i][0] + box_dim[i][0];
                     z1 = (p[2] > box_pos[i][2]) ? p[2] : box_pos[i][2];
                     z2 = (p[2] + d[2] < box_pos[i][2] + box_dim[i][2]) ?
                          p[2] + d[2] : box_pos[i][2] + box_dim[i][2];
                     if (x1 < x2 && z1 < z2) begin
                        sup += (x2 - x1) * (z2 - z1);
                        if (sup > 64'h7FFFFFFF) sup = 64'h7FFFFFFF;
                     end
                  end
               end
            end
            r.in_bounds = inb;
            r.overlaps = ovl;
            r.on_floor = (p[1] == 0);
            r.support_sum = sup[30:0];
            r.base_area = base[30:0];
         end
         bpcs_pkg::OP_POINT: begin
            keep = 1;
            for (int k = 0; k < 3; k++)
               if (p[k] < 0 || p[k] > container[k]) keep = 0;
            for (int i = 0; i < box_count; i++) begin
               hit = 1;
               for (int k = 0; k < 3; k++)
                  if (p[k] < box_pos[i][k] || p[k] >= box_pos[i][k] + box_dim[i][k])
                     hit = 0;
               if (hit) keep = 0;
            end
            r.point_kept = keep;
         end
         default: box_count = 0;
      endcase
      pending.insert(pending.size(), r);
   endfunction

   function void check_result(box_result_type got);
      box_result_type exp;
      if (pending.size() == 0) begin
         $display("%0t: unexpected result status=%0b", $time, got.status);
         errors++;
         return;
      end
      exp = pending.pop_front();
      if (got.status !== exp.status) begin
         $display("%0t: status exp %0b got %0b", $time, exp.status, got.status);
         errors++;
      end
      if (got.in_bounds !== exp.in_bounds) begin
         $display("%0t: in_bounds exp %0b got %0b", $time, exp.in_bounds, got.in_bounds);
         errors++;
      end
      if (got.overlaps !== exp.overlaps) begin
         $display("%0t: overlaps exp %0b got %0b", $time, exp.overlaps, got.overlaps);
         errors++;
      end
      if (got.on_floor !== exp.on_floor) begin
         $display("%0t: on_floor exp %0b got %0b", $time, exp.on_floor, got.on_floor);
         errors++;
      end
      if (got.support_sum !== exp.support_sum) begin
         $display("%0t: support_sum exp %0d got %0d", $time,
                  exp.support_sum, got.support_sum);
         errors++;
      end
      if (got.base_area !== exp.base_area) begin
         $display("%0t: base_area exp %0d got %0d", $time, exp.base_area, got.base_area);
         errors++;
      end
      if (got.point_kept !== exp.point_kept) begin
         $display("%0t: point_kept exp %0b got %0b", $time, exp.point_kept,
                  got.point_kept);
         errors++;
      end
   endfunction
endclass

module box_placement_collision_support_tb;
   import bpcs_pkg::*;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [1:0]        req_operation = '0;
   logic signed [15:0] req_pos_x = '0;
   logic signed [15:0] req_pos_y = '0;
   logic signed [15:0] req_pos_z = '0;
   size_type          req_base_size_x = '0;
   size_type          req_base_size_y = '0;
   size_type          req_base_size_z = '0;
   logic [2:0]        req_orientation = '0;
   logic              rsp_strobe;
   logic              rsp_status;
   logic              rsp_in_bounds;
   logic              rsp_overlaps;
   logic              rsp_on_floor;
   logic [AreaBits-1:0] rsp_support_sum;
   logic [AreaBits-1:0] rsp_base_area;
   logic              rsp_point_kept;
   logic              csr_write_enable = 1'b0;
   logic [1:0]        csr_index = '0;
   size_type          csr_data = '0;

   box_scoreboard board;
   int                gap_percent;

   box_placement_collision_support dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      box_result_type got;
      if (!reset && rsp_strobe) begin
         got.status = rsp_status;
         got.in_bounds = rsp_in_bounds;
         got.overlaps = rsp_overlaps;
         got.on_floor = rsp_on_floor;
         got.support_sum = rsp_support_sum;
         got.base_area = rsp_base_area;
         got.point_kept = rsp_point_kept;
         board.check_result(got);
      end
   end

   task automatic write_container(size_type sx, size_type sy, size_type sz);
      size_type vals[3];
      logic [1:0] idx[3];
      vals = '{sx, sy, sz};
      idx = '{REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z};
      for (int i = 0; i < 3; i++) begin
         @(posedge clock);
         csr_write_enable <= 1'b1;
         csr_index <= idx[i];
         csr_data <= vals[i];
         board.container[i] = vals[i];
      end
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // The request is raised after the chosen gap and lowered at the edge that
   // completes the transfer, so it never sees two assignments in one step.
   task automatic send_request(logic [1:0] op, logic signed [15:0] px,
                               logic signed [15:0] py, logic signed [15:0] pz,
                               size_type bx, size_type by, size_type bz,
                               logic [2:0] orient);
      while ($urandom_range(99) < gap_percent) begin
         @(posedge clock);
         start <= 1'b0;
      end
      @(posedge clock);
      start <= 1'b1;
      req_operation <= op;
      req_pos_x <= px;
      req_pos_y <= py;
      req_pos_z <= pz;
      req_base_size_x <= bx;
      req_base_size_y <= by;
      req_base_size_z <= bz;
      req_orientation <= orient;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_request(op, px, py, pz, bx, by, bz, orient);
      start <= 1'b0;
   endtask

   task automatic drain();
      while (board.pending.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   function automatic logic signed [15:0] pick_coord();
      case ($urandom_range(9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return 16'(int'($urandom));
         default: return 16'($urandom_range(40));
      endcase
   endfunction

   function automatic size_type pick_size();
      case ($urandom_range(9))
         0: return 15'h7FFF;
         1: return 15'd0;
         2: return 15'($urandom);
         default: return 15'($urandom_range(1, 12));
      endcase
   endfunction

   task automatic random_phase(int count);
      logic [1:0] op;
      int roll;
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(99);
         op = (roll < 35) ? OP_PLACE : (roll < 70) ? OP_EVAL :
              (roll < 96) ? OP_POINT : OP_CLEAR;
         send_request(op, pick_coord(), pick_coord(), pick_coord(),
                      pick_size(), pick_size(), pick_size(), 3'($urandom_range(7)));
      end
   endtask

   initial begin
      board = new();
      board.clear_all();
      gap_percent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      // Evaluate with all-zero container right after reset.
      send_request(OP_EVAL, 0, 0, 0, 0, 0, 0, 0);
      drain();
      write_container(15'd30, 15'd30, 15'd30);
      send_request(OP_PLACE, 0, 0, 0, 10, 5, 8, 0);
      send_request(OP_PLACE, 20, 0, 0, 3, 4, 5, 1);
      send_request(OP_PLACE, -5, 40, 0, 0, 3, 3, 2);
      send_request(OP_PLACE, 0, 0, 10, 15'h7FFF, 15'h7FFF, 15'h7FFF, 3);
      for (int o = 0; o < 8; o++)
         send_request(OP_EVAL, 2, 5, 1, 4, 6, 3, 3'(o));
      send_request(OP_EVAL, 16'sh8000, 0, 16'sh7FFF, 15'h7FFF, 1, 15'h7FFF, 0);
      send_request(OP_EVAL, 10, 0, 0, 5, 5, 5, 0);
      send_request(OP_EVAL, 0, 5, 0, 0, 1, 0, 0);
      send_request(OP_POINT, 30, 30, 30, 0, 0, 0, 0);
      send_request(OP_POINT, 0, 0, 0, 0, 0, 0, 0);
      send_request(OP_POINT, 10, 5, 8, 0, 0, 0, 0);
      send_request(OP_POINT, -1, 16'sh7FFF, 0, 0, 0, 0, 0);
      send_request(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0);
      for (int n = 0; n < 66; n++)
         send_request(OP_PLACE, 16'(n), 0, 0, 1, 1, 1, 0);
      send_request(OP_POINT, 3, 0, 0, 0, 0, 0, 0);
      drain();
      write_container(15'd40, 15'd40, 15'd40);
      gap_percent = 0;
      random_phase(100);
      drain();
      write_container(15'h7FFF, 15'h7FFF, 15'h7FFF);
      gap_percent = 66;
      random_phase(110);
      drain();
      write_container(15'd0, 15'd20, 15'd7);
      gap_percent = 24;
      random_phase(100);
      drain();
      write_container(15'd12, 15'd12, 15'd12);
      gap_percent = 66;
      random_phase(100);
      drain();
      if (board.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #20ms;
      $display("DONE: errors detected");
      $finish;
   end
endmodule

@@ sim.f @@
rtl/core/bpcs_pkg.sv
rtl/core/bpcs_cell.sv
rtl/core/box_placement_collision_support.sv
test/box_placement_collision_support_tb.sv
